>>> design/mmcv_pkg.sv
`default_nettype none

package mmcv_pkg;

  // running command codes
  localparam logic [7:0] CMD_NOTE_OFF  = 8'h80;
  localparam logic [7:0] CMD_NOTE_ON   = 8'h90;
  localparam logic [7:0] CMD_POLY_PRES = 8'hA0;
  localparam logic [7:0] CMD_CTRL      = 8'hB0;
  localparam logic [7:0] CMD_PROGRAM   = 8'hC0;
  localparam logic [7:0] CMD_CHAN_PRES = 8'hD0;
  localparam logic [7:0] CMD_WHEEL     = 8'hE0;
  localparam logic [7:0] CMD_SYSEX     = 8'hF0;
  localparam logic [7:0] CMD_MTC       = 8'hF1;
  localparam logic [7:0] CMD_SONG_POS  = 8'hF2;
  localparam logic [7:0] CMD_SONG_SEL  = 8'hF3;
  localparam logic [7:0] CMD_EOX       = 8'hF7;

  localparam logic [7:0] STATUS_MASK  = 8'hF0;
  localparam logic [7:0] CHANNEL_MASK = 8'h0F;

  localparam logic [1:0] TGT_PITCH = 2'd0;
  localparam logic [1:0] TGT_VEL   = 2'd1;
  localparam logic [1:0] TGT_PRES  = 2'd2;
  localparam logic [1:0] TGT_WHEEL = 2'd3;

  localparam logic [1:0] GATE_NONE = 2'd0;
  localparam logic [1:0] GATE_ON   = 2'd1;
  localparam logic [1:0] GATE_OFF  = 2'd2;

  localparam int unsigned MAX_WORDS = 3;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  target;
    logic [1:0]  gate;
  } word_t;

  typedef struct packed {
    word_t [MAX_WORDS-1:0] words;
    logic [1:0]            cnt;
  } bundle_t;

endpackage

`default_nettype wire

>>> design/midi_mono_note_to_cv_parser.sv
// path: an accepted byte is captured in the input register, parsed combinationally, and its
//   writes are loaded into the output register once the pending writes have drained
// throughput: one byte per cycle while each byte yields at most one write and the output is
//   not stalled; a byte that yields two or three writes holds the input while they drain
// reset: rst_ni is asynchronous, active low; it clears the parser state, the listen
//   channel and any pending writes
`default_nettype none

module midi_mono_note_to_cv_parser import mmcv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  midi_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      out_value_o,
  output logic [1:0]       out_target_o,
  output logic [1:0]       gate_flag_o,
  output logic             last_o
);

  logic [3:0] listen_q;
  logic       ready;
  logic       take;
  bundle_t    bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q <= '0;
    end else if (cfg_we_i) begin
      listen_q <= cfg_wdata_i;
    end
  end

  mmcv_parse u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .midi_byte_i      (midi_byte_i),
    .listen_channel_i (listen_q),
    .ready_i          (ready),
    .take_o           (take),
    .bundle_o         (bundle)
  );

  mmcv_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .bundle_i     (bundle),
    .ready_o      (ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .out_target_o (out_target_o),
    .gate_flag_o  (gate_flag_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

>>> design/mmcv_parse.sv
`default_nettype none

module mmcv_parse import mmcv_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] midi_byte_i,
  input  wire logic [3:0] listen_channel_i,
  input  wire logic       ready_i,
  output logic            take_o,
  output bundle_t         bundle_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_D0,
    PH_D1,
    PH_SYSEX,
    PH_SYSCOM
  } phase_e;

  logic       vld_q;
  logic [7:0] byte_q;

  phase_e     phase_q, phase_d;
  logic [7:0] cmd_q, cmd_d;
  logic [3:0] chan_q, chan_d;
  logic [6:0] first_q, first_d;
  logic [6:0] wheel_q, wheel_d;
  logic       gate_q, gate_d;
  logic [6:0] note_q, note_d;

  logic       match;
  logic [6:0] dat;

  assign take_o     = vld_q & ready_i;
  assign in_stall_o = vld_q & ~ready_i;
  assign match      = (chan_q == listen_channel_i);
  assign dat        = byte_q[6:0];

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    chan_d   = chan_q;
    first_d  = first_q;
    wheel_d  = wheel_q;
    gate_d   = gate_q;
    note_d   = note_q;
    bundle_o = '0;
    if (byte_q[7]) begin
      if (byte_q < CMD_SYSEX) begin
        cmd_d   = byte_q & STATUS_MASK;
        chan_d  = 4'(byte_q & CHANNEL_MASK);
        phase_d = PH_D0;
      end else begin
        unique case (byte_q)
          CMD_SYSEX: begin
            cmd_d   = CMD_SYSEX;
            phase_d = PH_SYSEX;
          end
          CMD_MTC: begin
            cmd_d   = CMD_MTC;
            phase_d = PH_SYSCOM;
          end
          CMD_SONG_POS: begin
            cmd_d   = CMD_SONG_POS;
            phase_d = PH_D0;
          end
          CMD_SONG_SEL: begin
            cmd_d   = CMD_SONG_SEL;
            phase_d = PH_SYSCOM;
          end
          CMD_EOX: begin
            cmd_d   = CMD_EOX;
            phase_d = PH_IDLE;
          end
          default: ;
        endcase
      end
    end else begin
      unique case (cmd_q)
        CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_PRES, CMD_CTRL: begin
          if (phase_q == PH_D0) begin
            first_d = dat;
            phase_d = PH_D1;
          end else if (phase_q == PH_D1) begin
            phase_d = PH_D0;
            if (cmd_q == CMD_NOTE_OFF || (cmd_q == CMD_NOTE_ON && dat == 7'd0)) begin
              if (match && first_q == note_q) begin
                bundle_o.words[0] = '{value: {9'd0, first_q}, target: TGT_PITCH,
                                      gate: GATE_OFF};
                bundle_o.words[1] = '{value: {9'd0, dat}, target: TGT_VEL,
                                      gate: GATE_NONE};
                bundle_o.cnt      = 2'd2;
                gate_d            = 1'b0;
              end
            end else if (cmd_q == CMD_NOTE_ON && match) begin
              if (gate_q) begin
                bundle_o.words[0] = '{value: {9'd0, note_q}, target: TGT_PITCH,
                                      gate: GATE_OFF};
                bundle_o.words[1] = '{value: {9'd0, first_q}, target: TGT_PITCH,
                                      gate: GATE_ON};
                bundle_o.words[2] = '{value: {9'd0, dat}, target: TGT_VEL,
                                      gate: GATE_NONE};
                bundle_o.cnt      = 2'd3;
              end else begin
                bundle_o.words[0] = '{value: {9'd0, first_q}, target: TGT_PITCH,
                                      gate: GATE_ON};
                bundle_o.words[1] = '{value: {9'd0, dat}, target: TGT_VEL,
                                      gate: GATE_NONE};
                bundle_o.cnt      = 2'd2;
              end
              gate_d = 1'b1;
              note_d = first_q;
            end
          end
        end
        CMD_CHAN_PRES: begin
          if (match) begin
            bundle_o.words[0] = '{value: {9'd0, dat}, target: TGT_PRES, gate: GATE_NONE};
            bundle_o.cnt      = 2'd1;
          end
        end
        CMD_WHEEL, CMD_SONG_POS: begin
          if (phase_q == PH_D0) begin
            wheel_d = dat;
            phase_d = PH_D1;
          end else if (phase_q == PH_D1) begin
            if (cmd_q == CMD_WHEEL) begin
              phase_d = PH_D0;
              if (match) begin
                bundle_o.words[0] = '{value: {dat, wheel_q, 2'b00}, target: TGT_WHEEL,
                                      gate: GATE_NONE};
                bundle_o.cnt      = 2'd1;
              end
            end else begin
              phase_d = PH_IDLE;
            end
          end
        end
        CMD_PROGRAM: phase_d = PH_D0;
        CMD_MTC, CMD_SONG_SEL: phase_d = PH_IDLE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      chan_q  <= '0;
      first_q <= '0;
      wheel_q <= '0;
      gate_q  <= 1'b0;
      note_q  <= '0;
    end else begin
      if (!in_stall_o) begin
        vld_q <= in_valid_i;
      end
      if (take_o) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        chan_q  <= chan_d;
        first_q <= first_d;
        wheel_q <= wheel_d;
        gate_q  <= gate_d;
        note_q  <= note_d;
      end
    end
  end

  // input word register
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= midi_byte_i;
    end
  end

endmodule

`default_nettype wire

>>> design/mmcv_emit.sv
`default_nettype none

module mmcv_emit import mmcv_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    take_i,
  input  wire bundle_t bundle_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output logic [15:0]  out_value_o,
  output logic [1:0]   out_target_o,
  output logic [1:0]   gate_flag_o,
  output logic         last_o
);

  word_t [MAX_WORDS-1:0] words_q;
  logic [1:0]            rem_q;
  logic                  pop;

  assign out_valid_o  = (rem_q != 2'd0);
  assign pop          = out_valid_o & ~out_stall_i;
  assign ready_o      = (rem_q == 2'd0) | ((rem_q == 2'd1) & ~out_stall_i);
  assign out_value_o  = words_q[0].value;
  assign out_target_o = words_q[0].target;
  assign gate_flag_o  = words_q[0].gate;
  assign last_o       = (rem_q == 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else if (take_i) begin
      rem_q <= bundle_i.cnt;
    end else if (pop) begin
      rem_q <= rem_q - 2'd1;
    end
  end

  // pending words shift toward the output slot
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      words_q <= bundle_i.words;
    end else if (pop) begin
      words_q[0] <= words_q[1];
      words_q[1] <= words_q[2];
    end
  end

endmodule

`default_nettype wire

>>> design/mmcv_checker.sv
`default_nettype none

module mmcv_checker import mmcv_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] out_value_o,
  input wire logic [1:0]  out_target_o,
  input wire logic [1:0]  gate_flag_o,
  input wire logic        last_o
);

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_o)
      && $stable(out_target_o) && $stable(gate_flag_o) && $stable(last_o))
    else $error("stalled output word changed");

  // a word that is not last is followed at once by another valid word of its group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("write group broken");

  // only pitch writes carry a gate change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_target_o != TGT_PITCH |-> gate_flag_o == GATE_NONE)
    else $error("gate change on non-pitch write");

  // wheel writes are single and shifted left two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_target_o == TGT_WHEEL |-> last_o && out_value_o[1:0] == 2'b00)
    else $error("bad wheel write");

  // velocity always closes a note group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_target_o == TGT_VEL |-> last_o && out_value_o[15:7] == 9'd0)
    else $error("bad velocity write");

endmodule

bind midi_mono_note_to_cv_parser mmcv_checker u_mmcv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_value_o  (out_value_o),
  .out_target_o (out_target_o),
  .gate_flag_o  (gate_flag_o),
  .last_o       (last_o)
);

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;
  import mmcv_pkg::*;

  localparam logic [7:0] RT_CLOCK        = 8'hF8;
  localparam logic [7:0] RT_RESET        = 8'hFF;
  localparam logic [7:0] SYS_UNDEF_FIRST = 8'hF4;
  localparam logic [7:0] SYS_UNDEF_LAST  = 8'hF6;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [2:0] {PH_IDLE, PH_DATA1, PH_DATA2, PH_SYSEX, PH_SYSCOM} phase_e;
  typedef enum logic [1:0] {ENT_BYTE, ENT_CFG, ENT_DRAIN} entry_e;

  typedef struct {
    entry_e     kind;
    logic [7:0] data;
  } pending_t;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  target;
    logic [1:0]  gate;
    logic        last;
  } cv_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = 4'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  midi_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] out_value_o;
  logic [1:0]  out_target_o;
  logic [1:0]  gate_flag_o;
  logic        last_o;

  midi_mono_note_to_cv_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .midi_byte_i  (midi_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .out_target_o (out_target_o),
    .gate_flag_o  (gate_flag_o),
    .last_o       (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // parser state as the predictor sees it
  logic [3:0] listen_ch = 4'd0;
  logic [7:0] run_cmd = 8'd0;
  logic [3:0] run_chan = 4'd0;
  phase_e     phase = PH_IDLE;
  logic [6:0] first_data = 7'd0;
  logic [6:0] wheel_lo = 7'd0;
  logic       gate_is_on = 1'b0;
  logic [6:0] held_note = 7'd0;

  cv_write_t cv_writes_due[$];
  cv_write_t batch[$];
  pending_t  pending[$];
  int        errors = 0;
  int        bytes_queued = 0;
  logic [7:0] last_status = 8'd0;
  logic [6:0] note_guess = 7'd60;

  task automatic add_word(input logic [15:0] value, input logic [1:0] target,
                          input logic [1:0] gate);
    batch.push_back('{value, target, gate, 1'b0});
  endtask

  task automatic parse_midi_byte(input logic [7:0] b);
    logic note_off;
    if (b[7]) begin
      if (b < CMD_SYSEX) begin
        run_cmd = b & STATUS_MASK;
        run_chan = b[3:0];
        phase = PH_DATA1;
      end else begin
        case (b)
          CMD_SYSEX: begin run_cmd = b; phase = PH_SYSEX; end
          CMD_MTC, CMD_SONG_SEL: begin run_cmd = b; phase = PH_SYSCOM; end
          CMD_SONG_POS: begin run_cmd = b; phase = PH_DATA1; end
          CMD_EOX: begin run_cmd = b; phase = PH_IDLE; end
          default: ;
        endcase
      end
    end else begin
      case (run_cmd)
        CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_PRES, CMD_CTRL: begin
          if (phase == PH_DATA1) begin
            first_data = b[6:0];
            phase = PH_DATA2;
          end else if (phase == PH_DATA2) begin
            phase = PH_DATA1;
            note_off = run_cmd == CMD_NOTE_OFF || (run_cmd == CMD_NOTE_ON && b == 8'd0);
            if (run_chan == listen_ch) begin
              if (note_off) begin
                if (first_data == held_note) begin
                  add_word({9'd0, first_data}, TGT_PITCH, GATE_OFF);
                  add_word({8'd0, b}, TGT_VEL, GATE_NONE);
                  gate_is_on = 1'b0;
                end
              end else if (run_cmd == CMD_NOTE_ON) begin
                if (gate_is_on) add_word({9'd0, held_note}, TGT_PITCH, GATE_OFF);
                add_word({9'd0, first_data}, TGT_PITCH, GATE_ON);
                add_word({8'd0, b}, TGT_VEL, GATE_NONE);
                gate_is_on = 1'b1;
                held_note = first_data;
              end
            end
          end
        end
        CMD_CHAN_PRES: begin
          if (run_chan == listen_ch) add_word({8'd0, b}, TGT_PRES, GATE_NONE);
        end
        CMD_WHEEL, CMD_SONG_POS: begin
          if (phase == PH_DATA1) begin
            wheel_lo = b[6:0];
            phase = PH_DATA2;
          end else if (phase == PH_DATA2) begin
            if (run_cmd == CMD_WHEEL) begin
              phase = PH_DATA1;
              if (run_chan == listen_ch) add_word({b[6:0], wheel_lo, 2'b00}, TGT_WHEEL, GATE_NONE);
            end else begin
              phase = PH_IDLE;
            end
          end
        end
        CMD_PROGRAM: phase = PH_DATA1;
        CMD_MTC, CMD_SONG_SEL: phase = PH_IDLE;
        default: ;
      endcase
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) cv_writes_due.push_back(batch[i]);
    batch.delete();
  endtask

  task automatic push_byte(input logic [7:0] b);
    pending.push_back('{ENT_BYTE, b});
    if (b < RT_CLOCK) bytes_queued++;
  endtask

  task automatic push_data(input logic [6:0] d);
    if ($urandom_range(0, 11) == 0) push_byte(8'($urandom_range(RT_CLOCK, RT_RESET)));
    push_byte({1'b0, d});
  endtask

  task automatic push_status(input logic [7:0] st);
    if (st != last_status || $urandom_range(0, 2) == 0) push_byte(st);
    last_status = st;
  endtask

  task automatic push_system(input logic [7:0] st);
    push_byte(st);
    last_status = st;
  endtask

  task automatic gen_message(input logic [3:0] listen);
    int kind;
    int n;
    logic [3:0] ch;
    logic [6:0] note;
    kind = $urandom_range(0, 19);
    ch = ($urandom_range(0, 3) != 0) ? listen : 4'($urandom_range(0, 15));
    note = ($urandom_range(0, 2) != 0) ? note_guess : 7'($urandom_range(0, 127));
    case (kind)
      0, 1, 2, 3, 4, 5: begin
        push_status(CMD_NOTE_ON | ch);
        push_data(note);
        push_data(7'($urandom_range(1, 127)));
        note_guess = note;
      end
      6, 7, 8: begin
        push_status(CMD_NOTE_OFF | ch);
        push_data(note);
        push_data(7'($urandom_range(0, 127)));
      end
      9: begin
        push_status(CMD_NOTE_ON | ch);
        push_data(note);
        push_data(7'd0);
      end
      10: begin
        push_status(CMD_CHAN_PRES | ch);
        push_data(7'($urandom_range(0, 127)));
      end
      11, 12: begin
        push_status(CMD_WHEEL | ch);
        push_data(7'($urandom_range(0, 127)));
        push_data(7'($urandom_range(0, 127)));
      end
      13: begin
        push_status(CMD_PROGRAM | ch);
        push_data(7'($urandom_range(0, 127)));
      end
      14: begin
        push_status(($urandom_range(0, 1) != 0 ? CMD_POLY_PRES : CMD_CTRL) | ch);
        push_data(7'($urandom_range(0, 127)));
        push_data(7'($urandom_range(0, 127)));
      end
      15: begin
        push_system(CMD_SONG_POS);
        push_data(7'($urandom_range(0, 127)));
        push_data(7'($urandom_range(0, 127)));
      end
      16: begin
        push_system($urandom_range(0, 1) != 0 ? CMD_MTC : CMD_SONG_SEL);
        push_data(7'($urandom_range(0, 127)));
      end
      17: begin
        push_system(CMD_SYSEX);
        n = $urandom_range(0, 4);
        repeat (n) push_data(7'($urandom_range(0, 127)));
        push_system(CMD_EOX);
      end
      18: begin
        if ($urandom_range(0, 1) != 0)
          push_system(8'($urandom_range(SYS_UNDEF_FIRST, SYS_UNDEF_LAST)));
        else
          push_system(8'($urandom_range(0, 255)));
      end
      default: begin
        // message cut short after its first data byte
        push_status(($urandom_range(0, 1) != 0 ? CMD_NOTE_ON : CMD_NOTE_OFF) | ch);
        push_data(note);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // sender
  int   gap_left = 0;
  int   quiet_cycles = 0;
  logic no_gap = 1'b0;

  always @(posedge clk_i) begin
    logic       valid_nxt;
    logic [7:0] data_nxt;
    logic       we_nxt;
    logic [3:0] wdata_nxt;
    valid_nxt = in_valid_i;
    data_nxt = midi_byte_i;
    we_nxt = 1'b0;
    wdata_nxt = cfg_wdata_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        parse_midi_byte(midi_byte_i);
        valid_nxt = 1'b0;
        if ($urandom_range(0, 15) == 0) no_gap = !no_gap;
        gap_left = no_gap ? 0 : $urandom_range(0, 4);
      end
      if (!valid_nxt && pending.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending[0].kind == ENT_BYTE) begin
          valid_nxt = 1'b1;
          data_nxt = pending[0].data;
          void'(pending.pop_front());
        end else if (cv_writes_due.size() != 0) begin
          quiet_cycles = 0;
        end else if (quiet_cycles < SETTLE_CYCLES) begin
          quiet_cycles++;
        end else begin
          quiet_cycles = 0;
          if (pending[0].kind == ENT_CFG) begin
            we_nxt = 1'b1;
            wdata_nxt = pending[0].data[3:0];
            listen_ch = wdata_nxt;
          end
          void'(pending.pop_front());
        end
      end
    end
    in_valid_i <= valid_nxt;
    midi_byte_i <= data_nxt;
    cfg_we_i <= we_nxt;
    cfg_wdata_i <= wdata_nxt;
  end

  // receiver
  int   stall_left = 0;
  logic no_stall = 1'b0;

  always @(posedge clk_i) begin
    logic      stall_nxt;
    cv_write_t want;
    stall_nxt = out_stall_i;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (cv_writes_due.size() == 0) begin
          $display("%0t: unexpected word value %h target %0d gate %0d last %0d",
                   $time, out_value_o, out_target_o, gate_flag_o, last_o);
          errors++;
        end else begin
          want = cv_writes_due.pop_front();
          check_field("value", want.value, out_value_o);
          check_field("target", {14'd0, want.target}, {14'd0, out_target_o});
          check_field("gate", {14'd0, want.gate}, {14'd0, gate_flag_o});
          check_field("last", {15'd0, want.last}, {15'd0, last_o});
        end
        if ($urandom_range(0, 15) == 0) no_stall = !no_stall;
        stall_left = no_stall ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_nxt = 1'b1;
        stall_left--;
      end else begin
        stall_nxt = 1'b0;
      end
    end
    out_stall_i <= stall_nxt;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [3:0] plan [4];
    int target;
    plan[0] = 4'd15;
    plan[1] = 4'd0;
    plan[2] = 4'($urandom_range(1, 14));
    plan[3] = 4'd9;

    // directed words, listening on channel 0 after reset
    push_byte(8'h40);
    push_byte(CMD_NOTE_ON);  push_byte(8'h3C); push_byte(8'h7F);
    push_byte(8'h45);        push_byte(8'h01);
    push_byte(CMD_NOTE_OFF); push_byte(8'h45); push_byte(8'h00);
    push_byte(CMD_NOTE_ON);  push_byte(8'h45); push_byte(8'h00);
    push_byte(CMD_CHAN_PRES); push_byte(8'h7F);
    push_byte(CMD_WHEEL);    push_byte(8'h00); push_byte(8'h00);
    push_byte(8'h7F);        push_byte(RT_CLOCK); push_byte(8'h7F);
    push_byte(CMD_SONG_POS); push_byte(8'h12); push_byte(8'h34);
    push_byte(SYS_UNDEF_FIRST + 8'd1);
    push_byte(CMD_SYSEX);    push_byte(8'h11); push_byte(CMD_EOX);
    push_byte(CMD_PROGRAM);  push_byte(8'h03);
    pending.push_back('{ENT_DRAIN, 8'd0});

    foreach (plan[s]) begin
      pending.push_back('{ENT_CFG, {4'd0, plan[s]}});
      last_status = 8'd0;
      target = bytes_queued + 30;
      while (bytes_queued < target) gen_message(plan[s]);
      pending.push_back('{ENT_DRAIN, 8'd0});
      target = bytes_queued + 32;
      while (bytes_queued < target) gen_message(plan[s]);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid_i || cv_writes_due.size() != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (cv_writes_due.size() != 0) begin
      $display("%0t: %0d words never arrived", $time, cv_writes_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
